// ===== rtl/core/fifo_with_keyed_removal_core_assert.svh =====
// Assertion macros for the keyed-removal FIFO core.
`ifndef FIFO_WITH_KEYED_REMOVAL_CORE_ASSERT_SVH
`define FIFO_WITH_KEYED_REMOVAL_CORE_ASSERT_SVH

// Check that cons holds in the same cycle whenever ante holds.
`define FWKR_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante holds.
`define FWKR_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/fwkr_pkg.sv =====
// Shared types, codes and sizes for the keyed-removal FIFO core.
package fwkr_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int DATA_W      = 32;
    localparam int OUT_CNT_W   = 5;

    typedef enum logic [1:0] {
        OP_PUSH   = 2'd0,
        OP_POP    = 2'd1,
        OP_REMOVE = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STAT_DONE = 2'd0,
        STAT_MISS = 2'd1,
        STAT_FULL = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_APPLY
    } state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;   // latch the accepted input beat
        logic search;    // register the selected entry
        logic apply;     // update the store and load the result register
    } fwkr_cmd_t;

endpackage

// ===== rtl/core/fwkr_ctrl.sv =====
// Controller state machine: sequences capture, search and apply of one beat.
module fwkr_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    output fwkr_pkg::fwkr_cmd_t cmd
);
    import fwkr_pkg::*;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;
    logic   out_free;

    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;

    // Hold state and result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Next state, handshake and datapath commands
    always_comb begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        s_tready      = 1'b0;
        cmd           = '0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                cmd.search = 1'b1;
                state_next = ST_APPLY;
            end
            ST_APPLY: begin
                if (out_free) begin
                    cmd.apply     = 1'b1;
                    m_tvalid_next = 1'b1;
                    s_tready      = 1'b1;
                    if (s_tvalid) begin
                        cmd.capture = 1'b1;
                        state_next  = ST_SEARCH;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/fwkr_datapath.sv =====
// Datapath: compacted shift store of key/payload pairs, match search, result register.
module fwkr_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  fwkr_pkg::fwkr_cmd_t                 cmd,
    input  fwkr_pkg::op_t                       in_operation,
    input  logic signed [fwkr_pkg::DATA_W-1:0]  in_key,
    input  logic signed [fwkr_pkg::DATA_W-1:0]  in_payload,
    output fwkr_pkg::status_t                   out_status,
    output logic signed [fwkr_pkg::DATA_W-1:0]  out_removed_payload,
    output logic signed [fwkr_pkg::DATA_W-1:0]  out_head_key,
    output logic signed [fwkr_pkg::DATA_W-1:0]  out_head_payload,
    output logic [fwkr_pkg::OUT_CNT_W-1:0]      out_entry_count,
    output logic                                out_is_empty
);
    import fwkr_pkg::*;

    // Captured beat
    op_t               op_reg;
    logic [DATA_W-1:0] key_reg;
    logic [DATA_W-1:0] pay_reg;

    // Store cells, entry 0 is the head
    logic [DATA_W-1:0] key_cells_reg [QUEUE_DEPTH];
    logic [DATA_W-1:0] pay_cells_reg [QUEUE_DEPTH];
    logic [DATA_W-1:0] key_cells_next [QUEUE_DEPTH];
    logic [DATA_W-1:0] pay_cells_next [QUEUE_DEPTH];
    logic [CNT_W-1:0]  count_reg, count_next;

    // One-hot selected entry for pop or remove
    logic [QUEUE_DEPTH-1:0] sel_reg, sel_next;
    logic [QUEUE_DEPTH-1:0] hit;
    logic [QUEUE_DEPTH-1:0] shift_mask;

    // Result register
    status_t           status_reg, status_next;
    logic [DATA_W-1:0] removed_reg, removed_next;
    logic [DATA_W-1:0] head_key_reg, head_pay_reg;
    logic [OUT_CNT_W-1:0] entry_count_reg;
    logic              is_empty_reg;

    logic push_ok;
    logic do_shift;
    logic sel_any;

    // Latch the accepted beat
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg  <= in_operation;
            key_reg <= in_key;
            pay_reg <= in_payload;
        end
    end

    // Compare all valid entries and keep the match nearest the head; a pop picks the head
    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            hit[i] = (CNT_W'(i) < count_reg) && (key_cells_reg[i] == key_reg);
        end
        if (op_reg == OP_POP) begin
            sel_next = '0;
            sel_next[0] = (count_reg != '0);
        end else begin
            sel_next = hit & (~hit + QUEUE_DEPTH'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.search) begin
            sel_reg <= sel_next;
        end
    end

    // Next store contents: collapse at the selected entry, append on push
    always_comb begin
        sel_any    = (sel_reg != '0);
        push_ok    = (op_reg == OP_PUSH) && (count_reg < CNT_W'(QUEUE_DEPTH));
        do_shift   = ((op_reg == OP_POP) || (op_reg == OP_REMOVE)) && sel_any;
        shift_mask = ~(sel_reg - QUEUE_DEPTH'(1));
        removed_next = '0;
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            removed_next = removed_next | ({DATA_W{sel_reg[i]}} & pay_cells_reg[i]);
        end
        if (op_reg != OP_REMOVE) begin
            removed_next = '0;
        end
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            key_cells_next[i] = key_cells_reg[i];
            pay_cells_next[i] = pay_cells_reg[i];
            if (push_ok && (count_reg == CNT_W'(i))) begin
                key_cells_next[i] = key_reg;
                pay_cells_next[i] = pay_reg;
            end
        end
        for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
            if (do_shift && shift_mask[i]) begin
                key_cells_next[i] = key_cells_reg[i+1];
                pay_cells_next[i] = pay_cells_reg[i+1];
            end
        end
        count_next  = count_reg;
        status_next = STAT_DONE;
        unique case (op_reg)
            OP_PUSH: begin
                if (push_ok) begin
                    count_next = count_reg + CNT_W'(1);
                end else begin
                    status_next = STAT_FULL;
                end
            end
            OP_POP, OP_REMOVE: begin
                if (do_shift) begin
                    count_next = count_reg - CNT_W'(1);
                end else begin
                    status_next = STAT_MISS;
                end
            end
            OP_CLEAR: begin
                count_next = '0;
            end
            default: begin
                count_next = count_reg;
            end
        endcase
    end

    // Advance the fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.apply) begin
            count_reg <= count_next;
        end
    end

    // Update the store and load the result
    always_ff @(posedge aclk) begin
        if (cmd.apply) begin
            for (int i = 0; i < QUEUE_DEPTH; i++) begin
                key_cells_reg[i] <= key_cells_next[i];
                pay_cells_reg[i] <= pay_cells_next[i];
            end
            status_reg      <= status_next;
            removed_reg     <= removed_next;
            head_key_reg    <= (count_next != '0) ? key_cells_next[0] : '0;
            head_pay_reg    <= (count_next != '0) ? pay_cells_next[0] : '0;
            entry_count_reg <= OUT_CNT_W'(count_next);
            is_empty_reg    <= (count_next == '0);
        end
    end

    assign out_status          = status_reg;
    assign out_removed_payload = removed_reg;
    assign out_head_key        = head_key_reg;
    assign out_head_payload    = head_pay_reg;
    assign out_entry_count     = entry_count_reg;
    assign out_is_empty        = is_empty_reg;

endmodule

// ===== rtl/core/fifo_with_keyed_removal_core.sv =====
// Top level of the keyed-removal FIFO core: controller, datapath and checks.
//
// Channel   Dir  tdata (low bit up)                                tuser
// s_        in   key[31:0], payload[63:32], pad to 72              operation[1:0]
// m_        out  removed_payload[31:0], head_key[63:32],           status[1:0]
//                head_payload[95:64], entry_count[100:96],
//                is_empty[101], pad to 104
//
// Each beat is a search, a compare of all 16 entries against the key with a
// first-match pick, then the collapse of the shift store and the load of the
// result register. A new beat is taken in the cycle its predecessor applies.
// Reset clears the fill count and handshake state; the store needs no clearing.
// A stalled result holds the block in its apply step until the result is taken.
module fifo_with_keyed_removal_core (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [71:0]  s_tdata,   // key[31:0], payload[63:32], zero pad [71:64]
    input  logic [1:0]   s_tuser,   // operation[1:0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata,   // removed_payload[31:0], head_key[63:32],
                                    // head_payload[95:64], entry_count[100:96],
                                    // is_empty[101], zero pad [103:102]
    output logic [1:0]   m_tuser    // status[1:0]
);
    import fwkr_pkg::*;

    `include "fifo_with_keyed_removal_core_assert.svh"

    fwkr_cmd_t            cmd;
    status_t              status;
    logic [DATA_W-1:0]    removed_payload;
    logic [DATA_W-1:0]    head_key;
    logic [DATA_W-1:0]    head_payload;
    logic [OUT_CNT_W-1:0] entry_count;
    logic                 is_empty;

    fwkr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    fwkr_datapath u_datapath (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cmd                 (cmd),
        .in_operation        (op_t'(s_tuser)),
        .in_key              (s_tdata[31:0]),
        .in_payload          (s_tdata[63:32]),
        .out_status          (status),
        .out_removed_payload (removed_payload),
        .out_head_key        (head_key),
        .out_head_payload    (head_payload),
        .out_entry_count     (entry_count),
        .out_is_empty        (is_empty)
    );

    // Pack the result beat
    assign m_tdata = {2'b00, is_empty, entry_count, head_payload, head_key, removed_payload};
    assign m_tuser = status;

    // Checks on the core's own logic
    `FWKR_ASSERT_NEXT(a_no_back_to_back_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready, "input accepted in consecutive cycles")
    `FWKR_ASSERT_SAME(a_empty_flag_matches_count, aclk, aresetn, m_tvalid, is_empty == (entry_count == '0), "empty flag disagrees with entry count")
    `FWKR_ASSERT_SAME(a_empty_head_zero, aclk, aresetn, m_tvalid && is_empty, head_key == '0 && head_payload == '0, "head not zero on empty queue")
    `FWKR_ASSERT_SAME(a_full_status_count, aclk, aresetn, m_tvalid && status == STAT_FULL, entry_count == OUT_CNT_W'(QUEUE_DEPTH), "full status with queue not full")

endmodule
